// File: rtl/wcmi_pkg.sv
// Shared types and constants for the windowed colormap interpolator.
// No dependencies; the front end, back end and top level import this package.
package wcmi_pkg;

    localparam int          TABLE_DEPTH_DEF = 32;
    localparam int          QUEUE_DEPTH     = 2;
    localparam int          QUOT_BITS       = 15;
    localparam logic [15:0] ONE_Q           = 16'd32768;
    localparam logic [25:0] PIXEL_MAX       = 26'd255;
    localparam logic [33:0] HALF_LSB        = 34'd16384;

    typedef enum logic [1:0] {
        CFG_ENTRY_COUNT   = 2'd0,
        CFG_CHANNEL_COUNT = 2'd1,
        CFG_WINDOW_LOW    = 2'd2,
        CFG_WINDOW_HIGH   = 2'd3
    } t_cfg_idx;

    typedef enum logic [0:0] {
        CMD_WRITE_ROW = 1'b0,
        CMD_MAP_PIXEL = 1'b1
    } t_cmd;

    typedef struct packed {
        logic [5:0]  entry_count;
        logic [2:0]  channel_count;
        logic [15:0] window_low;
        logic [15:0] window_high;
    } t_cfg;

    typedef struct packed {
        logic        command;
        logic [4:0]  row_slot;
        logic [15:0] row_key;
        logic [63:0] row_color;
        logic [7:0]  pixel_code;
    } t_item;

    typedef struct packed {
        logic        is_pixel;
        logic        slot_ok;
        logic [4:0]  slot;
        logic [15:0] key;
        logic [63:0] color;
        logic [7:0]  code;
    } t_job;

    typedef struct packed {
        logic [15:0] red;
        logic [15:0] green;
        logic [15:0] blue;
        logic [15:0] alpha;
    } t_result;

endpackage

// File: rtl/wcmi_front.sv
// Front end: accepts input items, classifies them and queues them for the back end.
// Depends on wcmi_pkg.
module wcmi_front
    import wcmi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    output logic  o_full,
    input  t_item i_item,
    output logic  o_valid,
    output t_job  o_job,
    input  logic  i_take
);

    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int PW = $clog2(QUEUE_DEPTH);

    t_job          r_q [QUEUE_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;
    t_job          job;
    logic          acc;

    always_comb begin
        job.is_pixel = (i_item.command == CMD_MAP_PIXEL);
        job.slot_ok  = (32'(i_item.row_slot) < TABLE_DEPTH);
        job.slot     = i_item.row_slot;
        job.key      = i_item.row_key;
        job.color    = i_item.row_color;
        job.code     = i_item.pixel_code;
    end

    assign o_full  = (r_cnt == CW'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_q[r_rd];
    assign acc     = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_q[r_wr] <= job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (acc) begin
                r_wr <= PW'(32'(r_wr) + 1 == QUEUE_DEPTH ? 0 : 32'(r_wr) + 1);
            end
            if (i_take) begin
                r_rd <= PW'(32'(r_rd) + 1 == QUEUE_DEPTH ? 0 : 32'(r_rd) + 1);
            end
            r_cnt <= r_cnt + CW'(acc) - CW'(i_take);
        end
    end

endmodule

// File: rtl/wcmi_back.sv
// Back end: row table, serial divider, bisection sequencer, channel blend, result register.
// Depends on wcmi_pkg.
module wcmi_back
    import wcmi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg    i_cfg,
    input  logic    i_valid,
    input  t_job    i_job,
    output logic    o_take,
    output logic    o_rvalid,
    output t_result o_res,
    input  logic    i_pop
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int NW = $clog2(TABLE_DEPTH + 1);

    typedef enum logic [11:0] {
        S_IDLE   = 12'b000000000001,
        S_DIV    = 12'b000000000010,
        S_ROUND  = 12'b000000000100,
        S_BISECT = 12'b000000001000,
        S_BCMP   = 12'b000000010000,
        S_TIE    = 12'b000000100000,
        S_LO     = 12'b000001000000,
        S_HI     = 12'b000010000000,
        S_FSET   = 12'b000100000000,
        S_CH     = 12'b001000000000,
        S_OUT    = 12'b010000000000,
        S_SPARE  = 12'b100000000000
    } t_state;

    t_state r_state, n_state;

    logic [15:0] key_mem [TABLE_DEPTH];
    logic [63:0] col_mem [TABLE_DEPTH];
    logic [15:0] r_kdata;
    logic [63:0] r_cdata;
    logic [AW-1:0] rd_addr;
    logic [31:0] slot_w;
    logic        mem_we;

    logic [NW-1:0] n, r_start, r_len, r_hi, mid, tie_idx, hi;
    logic [15:0] r_t, r_f, r_klo;
    logic [63:0] r_clo, r_chi;
    logic [25:0] r_rem, r_dvs, rem2;
    logic [15:0] r_q, q_rnd;
    logic [3:0]  r_cnt;
    logic        r_sel;
    logic [1:0]  r_ch;
    logic [15:0] r_res [4];
    logic        r_ovalid;
    t_result     r_out;

    logic signed [25:0] p_num, p_den, f_num, f_den, a_num, a_den, nn, dd;
    logic        sel_frac, d_go;
    logic [15:0] d_res;

    logic [15:0] v1, v2, ch_val;
    logic signed [16:0] diff;
    logic signed [33:0] prod;
    logic signed [34:0] blend;

    assign o_take = (r_state == S_IDLE) && i_valid;
    assign slot_w = 32'(i_job.slot);
    assign mem_we = o_take && !i_job.is_pixel && i_job.slot_ok;

    // Clamp entry count to 1..TABLE_DEPTH.
    always_comb begin
        if (i_cfg.entry_count == '0) begin
            n = NW'(1);
        end else if (32'(i_cfg.entry_count) > TABLE_DEPTH) begin
            n = NW'(TABLE_DEPTH);
        end else begin
            n = NW'(i_cfg.entry_count);
        end
    end

    assign mid     = r_start + (r_len >> 1);
    assign tie_idx = (r_start == '0) ? NW'(1) : n - NW'(2);
    assign hi      = (r_start < n - NW'(1)) ? r_start + NW'(1) : r_start;

    always_comb begin
        case (r_state)
            S_BISECT: rd_addr = (r_len > NW'(1)) ? mid[AW-1:0] : tie_idx[AW-1:0];
            S_HI:     rd_addr = r_hi[AW-1:0];
            default:  rd_addr = r_start[AW-1:0];
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            key_mem[slot_w[AW-1:0]] <= i_job.key;
            col_mem[slot_w[AW-1:0]] <= i_job.color;
        end
        r_kdata <= key_mem[rd_addr];
        r_cdata <= col_mem[rd_addr];
    end

    // Divider setup shared by window position and blend fraction.
    always_comb begin
        p_num    = $signed(26'({i_job.code, 15'd0}) - 26'(i_cfg.window_low) * PIXEL_MAX);
        p_den    = $signed((26'(i_cfg.window_high) - 26'(i_cfg.window_low)) * PIXEL_MAX);
        f_num    = $signed(26'(r_t) - 26'(r_klo));
        f_den    = $signed(26'(r_kdata) - 26'(r_klo));
        sel_frac = (r_state == S_FSET);
        a_num    = sel_frac ? f_num : p_num;
        a_den    = sel_frac ? f_den : p_den;
        if (a_den < 0) begin
            nn = -a_num;
            dd = -a_den;
        end else begin
            nn = a_num;
            dd = a_den;
        end
        d_go = 1'b0;
        if (a_den == 0) begin
            d_res = (!sel_frac && !a_num[25]) ? ONE_Q : 16'd0;
        end else if (nn <= 0) begin
            d_res = 16'd0;
        end else if (nn >= dd) begin
            d_res = ONE_Q;
        end else begin
            d_res = 16'd0;
            d_go  = 1'b1;
        end
    end

    assign rem2  = {r_rem[24:0], 1'b0};
    assign q_rnd = r_q + 16'((r_rem + (r_dvs >> 1)) >= r_dvs);

    // Channel blend: v1 + (v2 - v1) * f, rounded, one channel per cycle; unused channels give 0, alpha 1.
    always_comb begin
        v1    = r_clo[16*r_ch +: 16];
        v2    = r_chi[16*r_ch +: 16];
        diff  = $signed({1'b0, v2}) - $signed({1'b0, v1});
        prod  = diff * $signed({1'b0, r_f});
        blend = $signed({4'd0, v1, 15'd0}) + 35'(prod) + $signed({1'b0, HALF_LSB});
        if ({1'b0, r_ch} < i_cfg.channel_count) begin
            ch_val = blend[30:15];
        end else if (r_ch == 2'd3) begin
            ch_val = ONE_Q;
        end else begin
            ch_val = 16'd0;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_take && i_job.is_pixel) begin
                    n_state = d_go ? S_DIV : S_BISECT;
                end
            end
            S_DIV: begin
                if (r_cnt == 4'(QUOT_BITS - 1)) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: n_state = r_sel ? S_CH : S_BISECT;
            S_BISECT: begin
                if (r_len > NW'(1)) begin
                    n_state = S_BCMP;
                end else if (n > NW'(1) && (r_start == '0 || r_start == n - NW'(1))) begin
                    n_state = S_TIE;
                end else begin
                    n_state = S_LO;
                end
            end
            S_BCMP:  n_state = S_BISECT;
            S_TIE:   n_state = S_LO;
            S_LO:    n_state = S_HI;
            S_HI:    n_state = S_FSET;
            S_FSET:  n_state = d_go ? S_DIV : S_CH;
            S_CH: begin
                if (r_ch == 2'd3) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                if (!r_ovalid || i_pop) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                r_start <= '0;
                r_len   <= n;
                r_sel   <= 1'b0;
                r_t     <= d_res;
                r_rem   <= nn;
                r_dvs   <= dd;
                r_q     <= '0;
                r_cnt   <= '0;
            end
            S_DIV: begin
                if (rem2 >= r_dvs) begin
                    r_rem <= rem2 - r_dvs;
                    r_q   <= {r_q[14:0], 1'b1};
                end else begin
                    r_rem <= rem2;
                    r_q   <= {r_q[14:0], 1'b0};
                end
                r_cnt <= r_cnt + 4'd1;
            end
            S_ROUND: begin
                if (r_sel) begin
                    r_f <= q_rnd;
                end else begin
                    r_t <= q_rnd;
                end
                r_ch <= '0;
            end
            S_BCMP: begin
                if (r_t < r_kdata) begin
                    r_len <= mid - r_start;
                end else begin
                    r_len   <= r_start + r_len - mid;
                    r_start <= mid;
                end
            end
            S_TIE: begin
                if (r_t == r_kdata) begin
                    r_start <= tie_idx;
                end
            end
            S_LO: r_hi <= hi;
            S_HI: begin
                r_klo <= r_kdata;
                r_clo <= r_cdata;
            end
            S_FSET: begin
                r_chi <= r_cdata;
                r_f   <= d_res;
                r_sel <= 1'b1;
                r_rem <= nn;
                r_dvs <= dd;
                r_q   <= '0;
                r_cnt <= '0;
                r_ch  <= '0;
            end
            S_CH: begin
                r_res[r_ch] <= ch_val;
                r_ch        <= r_ch + 2'd1;
            end
            default: ;
        endcase
    end

    // Result register: hold until popped.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (r_state == S_OUT && (!r_ovalid || i_pop)) begin
            r_ovalid <= 1'b1;
        end else if (i_pop) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_ovalid || i_pop)) begin
            r_out.red   <= r_res[0];
            r_out.green <= r_res[1];
            r_out.blue  <= r_res[2];
            r_out.alpha <= r_res[3];
        end
    end

    assign o_rvalid = r_ovalid;
    assign o_res    = r_out;

endmodule

// File: rtl/windowed_colormap_interpolator.sv
// Windowed colormap interpolator: row writes and pixel lookups behind a two-entry input queue.
// A row write lands in the table when the back end takes it from the queue. A pixel passes
// through the window-position divide when needed, the bisection (5 steps at 32 rows), an
// end-of-table tie check, the fraction divide when needed, and the channel blend. One pixel
// at a time: the back end takes no new item until the current result is in the result register.
// Reset (synchronous, active low) restores config defaults, empties queues; table not cleared.
module windowed_colormap_interpolator
    import wcmi_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input queue
    input  logic        push,
    output logic        full,
    input  logic        i_command,
    input  logic [4:0]  i_row_slot,
    input  logic [15:0] i_row_key,
    input  logic [15:0] i_row_red,
    input  logic [15:0] i_row_green,
    input  logic [15:0] i_row_blue,
    input  logic [15:0] i_row_alpha,
    input  logic [7:0]  i_pixel_code,
    // result queue
    output logic        empty,
    input  logic        pop,
    output logic [15:0] o_red,
    output logic [15:0] o_green,
    output logic [15:0] o_blue,
    output logic [15:0] o_alpha,
    // register port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    t_cfg    r_cfg;
    t_item   item;
    t_job    job;
    t_result res;
    logic    job_valid, take, rvalid, cfg_wr;
    t_cfg_idx cfg_idx;

    // Register port: writes complete in the access phase; pready tied high.
    assign pready  = 1'b1;
    assign cfg_idx = t_cfg_idx'(paddr[3:2]);
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.entry_count   <= 6'd2;
            r_cfg.channel_count <= 3'd4;
            r_cfg.window_low    <= 16'd0;
            r_cfg.window_high   <= ONE_Q;
        end else if (cfg_wr) begin
            case (cfg_idx)
                CFG_ENTRY_COUNT:   r_cfg.entry_count   <= pwdata[5:0];
                CFG_CHANNEL_COUNT: r_cfg.channel_count <= pwdata[2:0];
                CFG_WINDOW_LOW:    r_cfg.window_low    <= pwdata[15:0];
                CFG_WINDOW_HIGH:   r_cfg.window_high   <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (cfg_idx)
            CFG_ENTRY_COUNT:   prdata = 32'(r_cfg.entry_count);
            CFG_CHANNEL_COUNT: prdata = 32'(r_cfg.channel_count);
            CFG_WINDOW_LOW:    prdata = 32'(r_cfg.window_low);
            CFG_WINDOW_HIGH:   prdata = 32'(r_cfg.window_high);
            default:           prdata = '0;
        endcase
    end

    // Pack the input transfer; color channels red low through alpha high.
    always_comb begin
        item.command    = i_command;
        item.row_slot   = i_row_slot;
        item.row_key    = i_row_key;
        item.row_color  = {i_row_alpha, i_row_blue, i_row_green, i_row_red};
        item.pixel_code = i_pixel_code;
    end

    wcmi_front #(.TABLE_DEPTH(TABLE_DEPTH)) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .i_item  (item),
        .o_valid (job_valid),
        .o_job   (job),
        .i_take  (take)
    );

    wcmi_back #(.TABLE_DEPTH(TABLE_DEPTH)) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (job_valid),
        .i_job    (job),
        .o_take   (take),
        .o_rvalid (rvalid),
        .o_res    (res),
        .i_pop    (pop)
    );

    // Result transfer side.
    assign empty   = !rvalid;
    assign o_red   = res.red;
    assign o_green = res.green;
    assign o_blue  = res.blue;
    assign o_alpha = res.alpha;

endmodule

// File: rtl/wcmi_checker.sv
// Port-level checks for the windowed colormap interpolator, bound to the top level.
// Depends on windowed_colormap_interpolator port names.
module wcmi_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        pop,
    input logic        empty,
    input logic        pready,
    input logic [15:0] o_red,
    input logic [15:0] o_alpha
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty && !full)
        else $error("queues not empty after reset");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push))
        else $error("full rose without a transfer in");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_red) && $stable(o_alpha))
        else $error("stalled result changed");

endmodule

bind windowed_colormap_interpolator wcmi_checker u_wcmi_checker (.*);

// File: tb/sv/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for windowed_colormap_interpolator: row writes, pixel lookups, registers.
// Depends on rtl/wcmi_pkg.sv and rtl/windowed_colormap_interpolator.sv.
module tb;
    import wcmi_pkg::*;

    localparam int DEPTH       = 32;
    localparam int SETTLE_CYC  = 100;  // a row write or pixel may still be in flight
    localparam int CYCLE_LIMIT = 600000;

    typedef enum logic [1:0] {
        OP_INPUT,   // one transfer into the input queue
        OP_REG,     // one register write, only once the block is quiet
        OP_DRAIN    // hold the sender until every result is back
    } t_op_kind;

    typedef struct {
        t_op_kind    kind;
        t_cmd        cmd;
        logic [4:0]  slot;
        logic [15:0] key;
        logic [63:0] color;
        logic [7:0]  code;
        int          gap;
        t_cfg_idx    reg_idx;
        logic [31:0] reg_val;
    } t_stim;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        push = 1'b0;
    logic        full;
    logic        i_command = 1'b0;
    logic [4:0]  i_row_slot = '0;
    logic [15:0] i_row_key = '0;
    logic [15:0] i_row_red = '0;
    logic [15:0] i_row_green = '0;
    logic [15:0] i_row_blue = '0;
    logic [15:0] i_row_alpha = '0;
    logic [7:0]  i_pixel_code = '0;
    logic        empty;
    logic        pop = 1'b0;
    logic [15:0] o_red, o_green, o_blue, o_alpha;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    windowed_colormap_interpolator dut (
        .i_clk, .i_rst_n,
        .push, .full, .i_command, .i_row_slot, .i_row_key,
        .i_row_red, .i_row_green, .i_row_blue, .i_row_alpha, .i_pixel_code,
        .empty, .pop, .o_red, .o_green, .o_blue, .o_alpha,
        .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
    );

    // Run the clock with a 4 ns period.
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // Shadow of the block's table and registers, used to predict each pixel.
    logic [15:0] key_shadow [DEPTH];
    logic [63:0] color_shadow [DEPTH];
    logic [5:0]  entries_reg = 6'd2;
    logic [2:0]  channels_reg = 3'd4;
    logic [15:0] win_low_reg = 16'd0;
    logic [15:0] win_high_reg = 16'd32768;

    t_stim   stim_q[$];
    t_result rgba_expect_q[$];
    int      error_count = 0;
    bit      stim_loaded = 1'b0;

    // Round-half-up of 32768*num/den, clamped to 0..32768; den is nonzero.
    function automatic int q15_ratio(longint num, longint den);
        if (den < 0) begin
            num = -num;
            den = -den;
        end
        if (num <= 0) return 0;
        if (num >= den) return 32768;
        return int'((num * 32768 + den / 2) / den);
    endfunction

    // Position of a grey code inside the window, Q1.15.
    function automatic int window_pos(logic [7:0] code, logic [15:0] wlo, logic [15:0] whi);
        longint num, den;
        num = longint'(code) * 32768 - 255 * longint'(wlo);
        den = 255 * (longint'(whi) - longint'(wlo));
        if (den == 0) return (num < 0) ? 0 : 32768;
        return q15_ratio(num, den);
    endfunction

    function automatic t_result map_pixel(logic [7:0] code);
        int          n, t, start, len, mid, lo, hi, f;
        longint      v1, v2;
        logic [15:0] chan [4];
        t_result     r;
        n = (entries_reg == 0) ? 1 : ((entries_reg > DEPTH) ? DEPTH : int'(entries_reg));
        t = window_pos(code, win_low_reg, win_high_reg);
        // Bisect the rows in use.
        start = 0;
        len = n;
        while (len > 1) begin
            mid = start + len / 2;
            if (t < key_shadow[mid]) begin
                len = mid - start;
            end else begin
                len = start + len - mid;
                start = mid;
            end
        end
        // Step off a tie at either end of the table.
        if (n > 1) begin
            if (start == 0 && t == key_shadow[1]) start = 1;
            else if (start == n - 1 && t == key_shadow[n - 2]) start = n - 2;
        end
        lo = start;
        hi = (start < n - 1) ? start + 1 : start;
        if (key_shadow[hi] == key_shadow[lo]) f = 0;
        else f = q15_ratio(longint'(t) - key_shadow[lo],
                           longint'(key_shadow[hi]) - key_shadow[lo]);
        for (int ch = 0; ch < 4; ch++) begin
            chan[ch] = '0;
            if (ch < channels_reg) begin
                v1 = color_shadow[lo][16*ch +: 16];
                v2 = color_shadow[hi][16*ch +: 16];
                chan[ch] = 16'((v1 * (32768 - f) + v2 * f + 16384) >>> 15);
            end else if (ch == 3) begin
                chan[ch] = 16'd32768;
            end
        end
        r.red = chan[0];
        r.green = chan[1];
        r.blue = chan[2];
        r.alpha = chan[3];
        return r;
    endfunction

    // Driver: feed the input queue and the register port from stim_q.
    t_stim cur_stim;
    int    gap_left = 0;
    bit    gap_taken = 1'b0;
    int    settle_cnt = 0;

    always @(posedge i_clk) begin
        bit raise;
        raise = 1'b0;
        if (!i_rst_n) begin
            push <= 1'b0;
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end else if (push && full) begin
            // hold the offered item
        end else begin
            if (push) begin
                // transfer accepted: update the shadow or queue the expected color
                if (cur_stim.cmd == CMD_WRITE_ROW) begin
                    key_shadow[cur_stim.slot] = cur_stim.key;
                    color_shadow[cur_stim.slot] = cur_stim.color;
                end else begin
                    rgba_expect_q.push_back(map_pixel(cur_stim.code));
                end
            end
            if (psel && !penable) begin
                penable <= 1'b1;
            end else if (psel) begin
                // register written at this edge
                case (cur_stim.reg_idx)
                    CFG_ENTRY_COUNT:   entries_reg = cur_stim.reg_val[5:0];
                    CFG_CHANNEL_COUNT: channels_reg = cur_stim.reg_val[2:0];
                    CFG_WINDOW_LOW:    win_low_reg = cur_stim.reg_val[15:0];
                    CFG_WINDOW_HIGH:   win_high_reg = cur_stim.reg_val[15:0];
                    default: ;
                endcase
                psel <= 1'b0;
                penable <= 1'b0;
                pwrite <= 1'b0;
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
            end else if (stim_q.size() > 0) begin
                case (stim_q[0].kind)
                    OP_INPUT: begin
                        if (stim_q[0].gap > 0 && !gap_taken) begin
                            gap_left <= stim_q[0].gap - 1;
                            gap_taken = 1'b1;
                        end else begin
                            cur_stim = stim_q.pop_front();
                            gap_taken = 1'b0;
                            raise = 1'b1;
                            i_command <= cur_stim.cmd;
                            i_row_slot <= cur_stim.slot;
                            i_row_key <= cur_stim.key;
                            i_row_red <= cur_stim.color[15:0];
                            i_row_green <= cur_stim.color[31:16];
                            i_row_blue <= cur_stim.color[47:32];
                            i_row_alpha <= cur_stim.color[63:48];
                            i_pixel_code <= cur_stim.code;
                        end
                    end
                    OP_REG: begin
                        // write only once nothing is expected and the pipe has settled
                        if (rgba_expect_q.size() != 0) begin
                            settle_cnt = 0;
                        end else if (settle_cnt < SETTLE_CYC) begin
                            settle_cnt++;
                        end else begin
                            settle_cnt = 0;
                            cur_stim = stim_q.pop_front();
                            psel <= 1'b1;
                            pwrite <= 1'b1;
                            paddr <= 4'(cur_stim.reg_idx * 4);
                            pwdata <= cur_stim.reg_val;
                        end
                    end
                    OP_DRAIN: begin
                        if (rgba_expect_q.size() == 0) void'(stim_q.pop_front());
                    end
                    default: void'(stim_q.pop_front());
                endcase
            end
            push <= raise;
        end
    end

    // Monitor: pop results with random stalls and check them against the prediction.
    int  stall_left = 0;
    int  result_count = 0;
    bit  calm_rx = 1'b0;

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                result_count++;
                if (rgba_expect_q.size() == 0) begin
                    $error("unexpected result red=%0d green=%0d blue=%0d alpha=%0d",
                           o_red, o_green, o_blue, o_alpha);
                    error_count++;
                end else begin
                    want = rgba_expect_q.pop_front();
                    if (o_red !== want.red) begin
                        $error("red: expected %0d, got %0d", want.red, o_red);
                        error_count++;
                    end
                    if (o_green !== want.green) begin
                        $error("green: expected %0d, got %0d", want.green, o_green);
                        error_count++;
                    end
                    if (o_blue !== want.blue) begin
                        $error("blue: expected %0d, got %0d", want.blue, o_blue);
                        error_count++;
                    end
                    if (o_alpha !== want.alpha) begin
                        $error("alpha: expected %0d, got %0d", want.alpha, o_alpha);
                        error_count++;
                    end
                end
                if (result_count % 64 == 0) calm_rx = ~calm_rx;
                // long hold-off once, while the sender keeps offering pixels
                if (result_count == 120) stall_left = 400;
                else stall_left = calm_rx ? 0 : $urandom_range(0, 8);
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                pop <= 1'b0;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    // Cycle limit.
    int cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Stimulus builders.
    bit calm_tx = 1'b0;

    function automatic int draw_gap();
        return calm_tx ? 0 : $urandom_range(0, 8);
    endfunction

    function automatic void add_row(int slot, logic [15:0] key, logic [63:0] color);
        t_stim s;
        s = '{kind: OP_INPUT, cmd: CMD_WRITE_ROW, slot: 5'(slot), key: key, color: color,
              code: 8'($urandom), gap: draw_gap(), reg_idx: CFG_ENTRY_COUNT, reg_val: '0};
        stim_q.push_back(s);
    endfunction

    function automatic void add_pixel(logic [7:0] code);
        t_stim s;
        s = '{kind: OP_INPUT, cmd: CMD_MAP_PIXEL, slot: 5'($urandom), key: 16'($urandom),
              color: {$urandom, $urandom}, code: code, gap: draw_gap(),
              reg_idx: CFG_ENTRY_COUNT, reg_val: '0};
        stim_q.push_back(s);
    endfunction

    function automatic void add_reg(t_cfg_idx idx, logic [31:0] val);
        t_stim s;
        s = '{kind: OP_DRAIN, cmd: CMD_WRITE_ROW, slot: '0, key: '0, color: '0, code: '0,
              gap: 0, reg_idx: idx, reg_val: val};
        stim_q.push_back(s);
        s.kind = OP_REG;
        stim_q.push_back(s);
    endfunction

    function automatic logic [15:0] q15_value();
        case ($urandom_range(0, 9))
            0: return 16'd0;
            1: return 16'd32768;
            2: return 16'($urandom);  // out of range noise
            default: return 16'($urandom_range(0, 32768));
        endcase
    endfunction

    function automatic logic [63:0] random_color();
        return {q15_value(), q15_value(), q15_value(), q15_value()};
    endfunction

    initial begin
        int          n, prev, code_walk;
        logic [15:0] wlo, whi;
        logic [15:0] k;

        // Fill every row so that no lookup reads an unwritten entry.
        for (int i = 0; i < DEPTH; i++)
            add_row(i, (i == DEPTH - 1) ? 16'd32768 : 16'(i * 1057), random_color());

        // Directed: reset settings first, then extremes and the special cases.
        add_pixel(8'd0);
        add_pixel(8'd255);
        add_pixel(8'd128);
        add_row(0, 16'd0, 64'h8000_0000_FFFF_0000);
        add_row(1, 16'd8224, 64'h0000_8000_0000_FFFF);
        add_pixel(8'd0);
        add_pixel(8'd64);   // lands exactly on the second key
        add_pixel(8'd255);
        add_reg(CFG_ENTRY_COUNT, 32'd0);     // zero rows behaves as one
        add_pixel(8'd200);
        add_reg(CFG_ENTRY_COUNT, 32'd63);    // saturates at the table depth
        add_reg(CFG_CHANNEL_COUNT, 32'd0);   // no channels, alpha still one
        add_pixel(8'd255);
        add_pixel(8'd1);
        add_reg(CFG_CHANNEL_COUNT, 32'd7);
        add_reg(CFG_WINDOW_LOW, 32'd16384);
        add_reg(CFG_WINDOW_HIGH, 32'd16384); // empty window
        add_pixel(8'd127);
        add_pixel(8'd128);
        add_reg(CFG_WINDOW_HIGH, 32'd0);     // inverted window
        add_pixel(8'd100);
        add_pixel(8'd10);
        add_reg(CFG_WINDOW_LOW, 32'hFFFF_FFFF);
        add_pixel(8'd255);

        // Random phases: settings, a fresh, mostly sorted table, then a pixel stream with some row writes.
        for (int ph = 0; ph < 12; ph++) begin
            calm_tx = (ph % 4 == 3);
            case ($urandom_range(0, 3))
                0: n = 1;
                1: n = DEPTH;
                default: n = $urandom_range(2, 12);
            endcase
            add_reg(CFG_ENTRY_COUNT, (ph == 5) ? 32'd0 : (ph == 6) ? 32'd40 : 32'(n));
            add_reg(CFG_CHANNEL_COUNT, 32'($urandom_range(0, 7)));
            case ($urandom_range(0, 4))
                0: begin wlo = 16'd0; whi = 16'd32768; end
                1: begin wlo = q15_value(); whi = wlo; end
                2: begin whi = q15_value(); wlo = q15_value(); end
                default: begin
                    wlo = 16'($urandom_range(0, 16000));
                    whi = 16'($urandom_range(wlo + 1, 32768));
                end
            endcase
            add_reg(CFG_WINDOW_LOW, {16'($urandom), wlo});
            add_reg(CFG_WINDOW_HIGH, 32'(whi));
            prev = 0;
            code_walk = 0;
            for (int i = 0; i < n; i++) begin
                // Mostly keys taken from pixel positions so ties occur; some broken order.
                case ($urandom_range(0, 9))
                    0: k = q15_value();
                    1, 2: k = 16'(prev);
                    3, 4: k = 16'((prev + $urandom_range(0, 4000) > 32768) ?
                                  32768 : prev + $urandom_range(0, 4000));
                    default: begin
                        code_walk = (code_walk + $urandom_range(0, 40) > 255) ?
                                    255 : code_walk + $urandom_range(0, 40);
                        k = 16'(window_pos(8'(code_walk), 16'd0, 16'd32768));
                        if (k < prev) k = 16'(prev);
                    end
                endcase
                prev = k;
                add_row(i, k, random_color());
            end
            for (int i = 0; i < 45; i++) begin
                if ($urandom_range(0, 19) == 0)
                    add_row($urandom_range(0, DEPTH - 1), q15_value(), random_color());
                else
                    add_pixel(8'($urandom));
            end
        end
        stim_loaded = 1'b1;
    end

    // Reset once, then wait for the stimulus to drain and the results to come back.
    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (stim_loaded);
        while (stim_q.size() != 0 || push || psel || rgba_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (rgba_expect_q.size() != 0) begin
            $error("%0d results never arrived", rgba_expect_q.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
